>>> rtl/cbr_pkg.sv
// shared types, register indexes, command codes and coefficients for the camera
// byte to rgb converter
// no dependencies
package cbr_pkg;

  localparam int BYTE_W = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAY_ONLY    = 2'd1;

  // pixel formats
  localparam logic [1:0] FMT_NIBBLE = 2'd0;
  localparam logic [1:0] FMT_MONO   = 2'd1;
  localparam logic [1:0] FMT_RGB888 = 2'd2;
  localparam logic [1:0] FMT_YCC422 = 2'd3;

  // group commands from front to back
  localparam logic [2:0] CMD_GRAY  = 3'd0;
  localparam logic [2:0] CMD_RGB   = 3'd1;
  localparam logic [2:0] CMD_SUM3  = 3'd2;
  localparam logic [2:0] CMD_YGRAY = 3'd3;
  localparam logic [2:0] CMD_YCC   = 3'd4;

  // per-pixel operations inside the back end
  localparam logic [1:0] OP_PASS = 2'd0;
  localparam logic [1:0] OP_SUM3 = 2'd1;
  localparam logic [1:0] OP_YCC  = 2'd2;

  // q16 coefficients
  localparam logic signed [17:0] COEF_CR_R = 18'sd91881;
  localparam logic signed [17:0] COEF_CB_G = 18'sd21889;
  localparam logic signed [17:0] COEF_CR_G = 18'sd46792;
  localparam logic signed [17:0] COEF_CB_B = 18'sd116129;
  localparam int COEF_SHIFT = 16;
  localparam logic [8:0] CHROMA_OFS = 9'd128;

  // floor(s/3) == (s*683)>>11 for s up to 765
  localparam logic [10:0] DIV3_RECIP = 11'd683;
  localparam int DIV3_SHIFT = 11;

  typedef struct packed {
    logic [2:0]        kind;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
  } cmd_t;

  function automatic logic [BYTE_W-1:0] clamp_byte(input logic signed [10:0] v);
    logic [BYTE_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = v[BYTE_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/cbr_if.sv
// valid/ready channel interfaces: camera bytes in, pixels out, register writes
// depends on cbr_pkg
interface cbr_in_if import cbr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;
  logic              frame_start;

  modport source (output valid, byte_in, frame_start, input ready);
  modport sink (input valid, byte_in, frame_start, output ready);
endinterface

interface cbr_out_if import cbr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;
  logic              last_pixel;

  modport source (output valid, red, green, blue, last_pixel, input ready);
  modport sink (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface cbr_cfg_if import cbr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink (input valid, reg_index, wr_data, output ready);
endinterface

>>> rtl/cbr_front.sv
// front end: config registers, byte phase tracking and group assembly into commands
// depends on cbr_pkg and cbr_if
module cbr_front import cbr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  cbr_in_if.sink      in_ch,
  cbr_cfg_if.sink     cfg_ch,
  input  logic        q_ready,
  output logic        q_push,
  output cmd_t        q_cmd
);

  logic [1:0]        fmt_r;
  logic              gray_r;
  logic [1:0]        phase_r;
  logic [1:0]        phase_nxt;
  logic [BYTE_W-1:0] held_r   [3];
  logic [BYTE_W-1:0] held_nxt [3];
  logic [1:0]        eff_phase;
  logic              emit;
  logic              acc;
  logic              cfg_wr;

  assign acc          = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = q_ready;
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;
  assign q_push       = acc && emit;

  always_comb begin
    eff_phase = in_ch.frame_start ? 2'd0 : phase_r;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    emit      = 1'b0;
    q_cmd     = '0;
    unique case (fmt_r)
      FMT_NIBBLE: begin
        emit      = 1'b1;
        phase_nxt = 2'd0;
        q_cmd.kind = CMD_GRAY;
        q_cmd.b0   = {4'b0, in_ch.byte_in[3:0]};
      end
      FMT_MONO: begin
        emit      = 1'b1;
        phase_nxt = 2'd0;
        q_cmd.kind = CMD_GRAY;
        q_cmd.b0   = in_ch.byte_in;
      end
      FMT_RGB888: begin
        if (eff_phase < 2'd2) begin
          held_nxt[eff_phase] = in_ch.byte_in;
          phase_nxt = eff_phase + 2'd1;
        end else begin
          emit      = 1'b1;
          phase_nxt = 2'd0;
          q_cmd.kind = gray_r ? CMD_SUM3 : CMD_RGB;
          q_cmd.b0   = held_r[0];
          q_cmd.b1   = held_r[1];
          q_cmd.b2   = in_ch.byte_in;
        end
      end
      FMT_YCC422: begin
        if (eff_phase != 2'd3) begin
          held_nxt[eff_phase] = in_ch.byte_in;
          phase_nxt = eff_phase + 2'd1;
        end else begin
          emit      = 1'b1;
          phase_nxt = 2'd0;
          q_cmd.kind = gray_r ? CMD_YGRAY : CMD_YCC;
          q_cmd.b0   = held_r[0];
          q_cmd.b1   = held_r[1];
          q_cmd.b2   = held_r[2];
          q_cmd.b3   = in_ch.byte_in;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r     <= FMT_YCC422;
      gray_r    <= 1'b0;
      phase_r   <= 2'd0;
      held_r[0] <= '0;
      held_r[1] <= '0;
      held_r[2] <= '0;
    end else begin
      // a format write drops any partial group
      if (cfg_wr && cfg_ch.reg_index == REG_PIXEL_FORMAT) begin
        fmt_r   <= cfg_ch.wr_data[1:0];
        phase_r <= 2'd0;
      end else if (acc) begin
        phase_r <= phase_nxt;
      end
      if (acc) begin
        held_r <= held_nxt;
      end
      if (cfg_wr && cfg_ch.reg_index == REG_GRAY_ONLY) begin
        gray_r <= cfg_ch.wr_data[0];
      end
    end
  end

endmodule

>>> rtl/cbr_queue.sv
// short command queue between front and back ends
// depends on cbr_pkg
module cbr_queue import cbr_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic push_ready,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count_r != FULL_CNT;
  assign head_valid = count_r != '0;
  assign head_cmd   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/cbr_back.sv
// back end: splits commands into pixels, multiplies, then adds, shifts and clamps
// depends on cbr_pkg and cbr_if
module cbr_back import cbr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     q_valid,
  input  cmd_t     q_cmd,
  output logic     q_pop,
  cbr_out_if.source out_ch
);

  // issue state
  logic              pix_idx_r;
  logic              two_pix;
  logic              op_last;
  logic [BYTE_W-1:0] y_sel;
  logic signed [8:0] cb_s;
  logic signed [8:0] cr_s;
  logic [9:0]        sum3;

  // product stage
  logic                b_valid_r;
  logic [1:0]          b_op_r;
  logic [1:0]          b_op_nxt;
  logic [BYTE_W-1:0]   b_c0_r, b_c1_r, b_c2_r;
  logic [BYTE_W-1:0]   b_c0_nxt, b_c1_nxt, b_c2_nxt;
  logic [20:0]         b_sum_r;
  logic signed [26:0]  p_rr_r, p_gb_r, p_gr_r, p_bb_r;
  logic                b_last_r;
  logic                b_adv;

  // output stage
  logic                out_valid_r;
  logic                out_load;
  logic [BYTE_W-1:0]   red_r, green_r, blue_r;
  logic [BYTE_W-1:0]   red_nxt, green_nxt, blue_nxt;
  logic                last_r;
  logic signed [10:0]  dr, dg, db, yv;
  logic [BYTE_W-1:0]   gray3;

  assign out_load = !out_valid_r || out_ch.ready;
  assign b_adv    = !b_valid_r || out_load;

  assign two_pix = (q_cmd.kind == CMD_YGRAY) || (q_cmd.kind == CMD_YCC);
  assign op_last = !two_pix || pix_idx_r;
  assign q_pop   = b_adv && q_valid && op_last;
  assign y_sel   = pix_idx_r ? q_cmd.b3 : q_cmd.b1;
  assign cb_s    = signed'({1'b0, q_cmd.b0} - CHROMA_OFS);
  assign cr_s    = signed'({1'b0, q_cmd.b2} - CHROMA_OFS);
  assign sum3    = {2'b0, q_cmd.b0} + {2'b0, q_cmd.b1} + {2'b0, q_cmd.b2};

  always_comb begin
    b_op_nxt = OP_PASS;
    b_c0_nxt = q_cmd.b0;
    b_c1_nxt = q_cmd.b1;
    b_c2_nxt = q_cmd.b2;
    unique case (q_cmd.kind)
      CMD_GRAY: begin
        b_c1_nxt = q_cmd.b0;
        b_c2_nxt = q_cmd.b0;
      end
      CMD_RGB: begin
        b_op_nxt = OP_PASS;
      end
      CMD_SUM3: begin
        b_op_nxt = OP_SUM3;
      end
      CMD_YGRAY: begin
        b_c0_nxt = y_sel;
        b_c1_nxt = y_sel;
        b_c2_nxt = y_sel;
      end
      CMD_YCC: begin
        b_op_nxt = OP_YCC;
        b_c0_nxt = y_sel;
      end
      default: begin
        b_op_nxt = OP_PASS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_idx_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else if (b_adv) begin
      b_valid_r <= q_valid;
      if (q_valid) begin
        pix_idx_r <= !op_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      b_op_r   <= b_op_nxt;
      b_c0_r   <= b_c0_nxt;
      b_c1_r   <= b_c1_nxt;
      b_c2_r   <= b_c2_nxt;
      b_sum_r  <= 21'(sum3) * 21'(DIV3_RECIP);
      p_rr_r   <= 27'(COEF_CR_R) * 27'(cr_s);
      p_gb_r   <= 27'(COEF_CB_G) * 27'(cb_s);
      p_gr_r   <= 27'(COEF_CR_G) * 27'(cr_s);
      p_bb_r   <= 27'(COEF_CB_B) * 27'(cb_s);
      b_last_r <= op_last;
    end
  end

  // arithmetic shift floors negative products
  always_comb begin
    dr    = 11'(p_rr_r >>> COEF_SHIFT);
    dg    = 11'(p_gb_r >>> COEF_SHIFT) + 11'(p_gr_r >>> COEF_SHIFT);
    db    = 11'(p_bb_r >>> COEF_SHIFT);
    yv    = signed'({3'b0, b_c0_r});
    gray3 = b_sum_r[DIV3_SHIFT +: BYTE_W];
    red_nxt   = b_c0_r;
    green_nxt = b_c1_r;
    blue_nxt  = b_c2_r;
    unique case (b_op_r)
      OP_PASS: begin
        red_nxt = b_c0_r;
      end
      OP_SUM3: begin
        red_nxt   = gray3;
        green_nxt = gray3;
        blue_nxt  = gray3;
      end
      OP_YCC: begin
        red_nxt   = clamp_byte(yv + dr);
        green_nxt = clamp_byte(yv - dg);
        blue_nxt  = clamp_byte(yv + db);
      end
      default: begin
        red_nxt = b_c0_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= b_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && b_valid_r) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      last_r  <= b_last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.red        = red_r;
  assign out_ch.green      = green_r;
  assign out_ch.blue       = blue_r;
  assign out_ch.last_pixel = last_r;

  // second pixel of a pair waits on the head command
  a_pair_head: assert property (@(posedge clk) disable iff (!rst_n)
    pix_idx_r |-> (q_valid && two_pix))
    else $error("second pixel issued without a two-pixel command at queue head");

  // first pixel of a pair is always followed closely by its partner
  a_pair_follow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !last_r) |-> (b_valid_r && b_last_r))
    else $error("first pixel of a pair on output without its partner behind it");

  // gray sum scaled by the reciprocal never exceeds one byte after the shift
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && b_op_r == OP_SUM3) |-> (b_sum_r < 21'(766 * 683)))
    else $error("rgb gray sum out of range");

endmodule

>>> rtl/camera_byte_stream_to_rgb_core.sv
// camera byte to rgb pixel converter, top level
// a byte that completes a group passes through the command queue, the product stage and
// the output register, a second ycbcr pixel after the first; throughput: one byte per cycle
// in, one pixel per cycle out, set by the single-issue back end, unless queue or output stall
// reset: pixel_format 3, gray_only 0, byte phase 0, command queue and pipeline empty
module camera_byte_stream_to_rgb_core import cbr_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cbr_in_if.sink     in_ch,
  cbr_cfg_if.sink    cfg_ch,
  cbr_out_if.source  out_ch
);

  logic q_ready;
  logic q_push;
  cmd_t q_push_cmd;
  logic q_valid;
  cmd_t q_head;
  logic q_pop;

  cbr_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .q_ready(q_ready),
    .q_push (q_push),
    .q_cmd  (q_push_cmd)
  );

  cbr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_push_cmd),
    .push_ready(q_ready),
    .pop       (q_pop),
    .head_valid(q_valid),
    .head_cmd  (q_head)
  );

  cbr_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_valid(q_valid),
    .q_cmd  (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
